/* sv/mtcqf_pkg.sv */
// constants for the midi time code quarter-frame generator
// no dependencies; imported by mtc_quarter_frame_generator
package mtcqf_pkg;

   // quarter-frame status byte
   localparam logic [7:0] QF_STATUS = 8'hF1;

   // rate code 30 fps non-drop, already placed at nibble bits 2..1
   localparam logic [3:0] RATE_BITS = 4'h6;

   // timecode radices
   localparam int unsigned FPS         = 30;
   localparam int unsigned SEC_PER_MIN = 60;
   localparam int unsigned MIN_PER_HR  = 60;
   localparam int unsigned HOURS_WRAP  = 31;

   // reciprocal constants: floor(x/15) = (x*MAGIC_15)>>35 for any 32-bit x,
   // floor(x/31) = (x*MAGIC_31)>>20 for x below 2^15
   localparam logic [31:0] MAGIC_15       = 32'h8888_8889;
   localparam int unsigned MAGIC_15_SHIFT = 35;
   localparam logic [15:0] MAGIC_31       = 16'd33826;
   localparam int unsigned MAGIC_31_SHIFT = 20;

   // field widths
   localparam int unsigned FRM_W = 5;
   localparam int unsigned SEC_W = 6;
   localparam int unsigned MIN_W = 6;
   localparam int unsigned HR_W  = 5;

   // piece indexes, in emission order
   localparam logic [2:0] PIECE_FRM_LO  = 3'd0;
   localparam logic [2:0] PIECE_FRM_HI  = 3'd1;
   localparam logic [2:0] PIECE_SEC_LO  = 3'd2;
   localparam logic [2:0] PIECE_SEC_HI  = 3'd3;
   localparam logic [2:0] PIECE_MIN_LO  = 3'd4;
   localparam logic [2:0] PIECE_MIN_HI  = 3'd5;
   localparam logic [2:0] PIECE_HR_LO   = 3'd6;
   localparam logic [2:0] PIECE_HR_RATE = 3'd7;

endpackage

/* sv/mtc_quarter_frame_generator.sv */
// midi time code quarter-frame generator, 30 fps non-drop
// top level; depends on mtcqf_pkg
//
// usage
//  - input beat: req_frame_count (signed frames) and req_is_playing, taken at a
//    rising edge with start high and busy low
//  - a negative count counts as frame zero; with req_is_playing low the beat
//    is taken and dropped, giving no output
//  - a playing beat gives eight output beats on consecutive cycles, pieces 0..7,
//    each shown for one cycle with rsp_strobe high; rsp_last_piece marks piece 7
//  - path: piece 0 reaches the outputs once the item has passed the six-stage
//    divide pipeline and been loaded into the beat emitter
//  - throughput: the emitter gives one piece per cycle, never stalled once
//    started; busy rises only when the pipeline's last stage holds an
//    item and the emitter is mid-sequence, so a new item follows the last
//    piece of the previous one without a gap
//  - the receiver cannot stall: every strobed beat is consumed
//  - reset (synchronous) empties the pipeline and stops the emitter
module mtc_quarter_frame_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_frame_count,
   input  logic        req_is_playing,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_status_byte,
   output logic [6:0]  rsp_data_byte,
   output logic [2:0]  rsp_piece_index,
   output logic        rsp_last_piece
);
   import mtcqf_pkg::*;

   // pipeline valid bits, stage 0..5
   logic [5:0] vld_ff, vld_in;

   // stage 0: clamped frame count
   logic [30:0] fr0_ff, fr0_in;
   // stage 1: frame count and total seconds
   logic [30:0] fr1_ff;
   logic [26:0] q1_1_ff, q1_1_in;
   // stage 2: frames, total seconds, total minutes
   logic [FRM_W-1:0] frm2_ff, frm2_in;
   logic [26:0]      q1_2_ff;
   logic [20:0]      q2_2_ff, q2_2_in;
   // stage 3: frames, seconds, total minutes, total hours
   logic [FRM_W-1:0] frm3_ff;
   logic [SEC_W-1:0] sec3_ff, sec3_in;
   logic [20:0]      q2_3_ff;
   logic [14:0]      q3_3_ff, q3_3_in;
   // stage 4: frames, seconds, minutes, total hours, hour wraps
   logic [FRM_W-1:0] frm4_ff;
   logic [SEC_W-1:0] sec4_ff;
   logic [MIN_W-1:0] min4_ff, min4_in;
   logic [14:0]      q3_4_ff;
   logic [9:0]       q4_4_ff, q4_4_in;
   // stage 5: full timecode
   logic [FRM_W-1:0] frm5_ff;
   logic [SEC_W-1:0] sec5_ff;
   logic [MIN_W-1:0] min5_ff;
   logic [HR_W-1:0]  hr5_ff, hr5_in;

   // beat emitter
   logic             act_ff, act_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [FRM_W-1:0] frm_e_ff;
   logic [SEC_W-1:0] sec_e_ff;
   logic [MIN_W-1:0] min_e_ff;
   logic [HR_W-1:0]  hr_e_ff;

   logic emit_ready;
   logic stall;
   logic advance;
   logic accept;

   // products
   logic [61:0] p1;
   logic [56:0] p2;
   logic [50:0] p3;
   logic [30:0] p4;
   logic [7:0]  frm_diff;
   logic [7:0]  sec_diff;
   logic [7:0]  min_diff;
   logic [7:0]  hr_diff;

   logic [3:0] nib;

   // emitter takes a new timecode when idle or on its last piece
   assign emit_ready = !act_ff || (cnt_ff == PIECE_HR_RATE);
   assign stall      = vld_ff[5] && !emit_ready;
   assign advance    = !stall;
   assign busy       = stall;
   assign accept     = start && !busy;

   // stage 0 input: sign bit set means frame zero
   assign fr0_in = req_frame_count[31] ? '0 : req_frame_count[30:0];

   // frames / 30 = (frames >> 1) / 15
   assign p1      = 62'(fr0_ff[30:1]) * 62'(MAGIC_15);
   assign q1_1_in = p1[MAGIC_15_SHIFT +: 27];

   // frames mod 30, seconds / 60 = (seconds >> 2) / 15
   assign frm_diff = fr1_ff[7:0] - 8'(q1_1_ff[7:0] * 8'(FPS));
   assign frm2_in  = frm_diff[FRM_W-1:0];
   assign p2       = 57'(q1_1_ff[26:2]) * 57'(MAGIC_15);
   assign q2_2_in  = p2[MAGIC_15_SHIFT +: 21];

   // seconds mod 60, minutes / 60
   assign sec_diff = q1_2_ff[7:0] - 8'(q2_2_ff[7:0] * 8'(SEC_PER_MIN));
   assign sec3_in  = sec_diff[SEC_W-1:0];
   assign p3       = 51'(q2_2_ff[20:2]) * 51'(MAGIC_15);
   assign q3_3_in  = p3[MAGIC_15_SHIFT +: 15];

   // minutes mod 60, hours / 31
   assign min_diff = q2_3_ff[7:0] - 8'(q3_3_ff[7:0] * 8'(MIN_PER_HR));
   assign min4_in  = min_diff[MIN_W-1:0];
   assign p4       = 31'(q3_3_ff) * 31'(MAGIC_31);
   assign q4_4_in  = p4[MAGIC_31_SHIFT +: 10];

   // hours mod 31
   assign hr_diff = q3_4_ff[7:0] - 8'(q4_4_ff[7:0] * 8'(HOURS_WRAP));
   assign hr5_in  = hr_diff[HR_W-1:0];

   // valid bits: items that do not play never enter
   always_comb begin
      vld_in = vld_ff;
      if (advance) begin
         vld_in = {vld_ff[4:0], accept && req_is_playing};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload stages, held together while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         fr0_ff  <= fr0_in;
         fr1_ff  <= fr0_ff;
         q1_1_ff <= q1_1_in;
         frm2_ff <= frm2_in;
         q1_2_ff <= q1_1_ff;
         q2_2_ff <= q2_2_in;
         frm3_ff <= frm2_ff;
         sec3_ff <= sec3_in;
         q2_3_ff <= q2_2_ff;
         q3_3_ff <= q3_3_in;
         frm4_ff <= frm3_ff;
         sec4_ff <= sec3_ff;
         min4_ff <= min4_in;
         q3_4_ff <= q3_3_ff;
         q4_4_ff <= q4_4_in;
         frm5_ff <= frm4_ff;
         sec5_ff <= sec4_ff;
         min5_ff <= min4_ff;
         hr5_ff  <= hr5_in;
      end
   end

   // emitter control: load on ready, else step to the next piece
   always_comb begin
      act_in = act_ff;
      cnt_in = cnt_ff;
      if (emit_ready) begin
         act_in = vld_ff[5];
         cnt_in = PIECE_FRM_LO;
      end else begin
         cnt_in = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         cnt_ff <= PIECE_FRM_LO;
      end else begin
         act_ff <= act_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_ready) begin
         frm_e_ff <= frm5_ff;
         sec_e_ff <= sec5_ff;
         min_e_ff <= min5_ff;
         hr_e_ff  <= hr5_ff;
      end
   end

   // nibble for the current piece
   always_comb begin
      case (cnt_ff)
         PIECE_FRM_LO:  nib = frm_e_ff[3:0];
         PIECE_FRM_HI:  nib = {3'b000, frm_e_ff[4]};
         PIECE_SEC_LO:  nib = sec_e_ff[3:0];
         PIECE_SEC_HI:  nib = {2'b00, sec_e_ff[5:4]};
         PIECE_MIN_LO:  nib = min_e_ff[3:0];
         PIECE_MIN_HI:  nib = {2'b00, min_e_ff[5:4]};
         PIECE_HR_LO:   nib = hr_e_ff[3:0];
         PIECE_HR_RATE: nib = RATE_BITS | {3'b000, hr_e_ff[4]};
         default:       nib = '0;
      endcase
   end

   assign rsp_strobe      = act_ff;
   assign rsp_status_byte = QF_STATUS;
   assign rsp_data_byte   = {cnt_ff, nib};
   assign rsp_piece_index = cnt_ff;
   assign rsp_last_piece  = (cnt_ff == PIECE_HR_RATE);

endmodule

/* tb/mtc_quarter_frame_generator_test.sv */
// self-checking testbench for the midi time code quarter-frame generator
// drives mtc_quarter_frame_generator through a directed table and random beats
// depends on mtcqf_pkg for the status byte, rate bits, radices and piece indexes
`timescale 1ns / 100ps

module mtc_quarter_frame_generator_test;
   import mtcqf_pkg::*;

   // one quarter-frame beat as it should appear on the rsp_ ports
   typedef struct packed {
      logic [7:0] status;
      logic [6:0] data;
      logic [2:0] piece;
      logic       last;
   } qf_beat_type;

   // one row of input stimulus; typed rows carry their eight data bytes literally
   typedef struct packed {
      logic [31:0]     count;
      logic            playing;
      logic            typed;
      logic [7:0][6:0] data_bytes;
   } stim_row_type;

   // data bytes at timecode 00:00:00:00, only the rate code in piece 7 is set
   localparam logic [7:0][6:0] ORIGIN_BYTES =
      {7'h76, 7'h60, 7'h50, 7'h40, 7'h30, 7'h20, 7'h10, 7'h00};
   // 16:00:00:00, hour bit 4 rides in piece 7 next to the rate code
   localparam logic [7:0][6:0] HOUR16_BYTES =
      {7'h77, 7'h60, 7'h50, 7'h40, 7'h30, 7'h20, 7'h10, 7'h00};

   localparam int DIRECTED_ROWS = 22;
   localparam int RANDOM_BEATS  = 210;
   localparam int DRAIN_LIMIT   = 500;    // cycles allowed for pending beats to emerge
   localparam int TAIL_CYCLES   = 16;     // margin beyond the pipeline and emitter latency, plus slack

   logic        clock;
   logic        reset           = 1'b1;
   logic        start           = 1'b0;
   logic        busy;
   logic [31:0] req_frame_count = '0;
   logic        req_is_playing  = 1'b0;
   logic        rsp_strobe;
   logic [7:0]  rsp_status_byte;
   logic [6:0]  rsp_data_byte;
   logic [2:0]  rsp_piece_index;
   logic        rsp_last_piece;

   // quarter frames still owed by the block, oldest first
   qf_beat_type  pending_quarter_frames[$];
   stim_row_type directed_rows[DIRECTED_ROWS];

   int          mismatches    = 0;
   int          beats_in      = 0;
   int          playing_in    = 0;
   int          beats_checked = 0;

   mtc_quarter_frame_generator dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_frame_count (req_frame_count),
      .req_is_playing  (req_is_playing),
      .rsp_strobe      (rsp_strobe),
      .rsp_status_byte (rsp_status_byte),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_piece_index (rsp_piece_index),
      .rsp_last_piece  (rsp_last_piece)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("mtc_quarter_frame_generator test failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // data byte of one piece: split the clamped position into timecode fields,
   // then pick the nibble that the piece carries
   function automatic logic [6:0] timecode_data_byte(input logic [31:0] count,
                                                     input logic [2:0] piece);
      logic [31:0] pos;
      logic [4:0]  frm;
      logic [5:0]  sec;
      logic [5:0]  mins;
      logic [4:0]  hrs;
      logic [3:0]  nib;
      // negative positions count as frame zero
      pos  = count[31] ? 32'd0 : count;
      frm  = 5'(pos % FPS);
      sec  = 6'((pos / FPS) % SEC_PER_MIN);
      mins = 6'((pos / (FPS * SEC_PER_MIN)) % MIN_PER_HR);
      hrs  = 5'((pos / (FPS * SEC_PER_MIN * MIN_PER_HR)) % HOURS_WRAP);
      case (piece)
         PIECE_FRM_LO:  nib = frm[3:0];
         PIECE_FRM_HI:  nib = {3'b000, frm[4]};
         PIECE_SEC_LO:  nib = sec[3:0];
         PIECE_SEC_HI:  nib = {2'b00, sec[5:4]};
         PIECE_MIN_LO:  nib = mins[3:0];
         PIECE_MIN_HI:  nib = {2'b00, mins[5:4]};
         PIECE_HR_LO:   nib = hrs[3:0];
         default:       nib = RATE_BITS | {3'b000, hrs[4]};
      endcase
      return {piece, nib};
   endfunction

   // present one input beat and hold it until the block takes it, then queue
   // the quarter frames it owes; start stays high for a back-to-back follower
   task automatic send_beat(input stim_row_type row);
      qf_beat_type qf;
      req_frame_count <= row.count;
      req_is_playing  <= row.playing;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_in++;
      if (row.playing) begin
         playing_in++;
         for (int k = 0; k < 8; k++) begin
            qf.status = QF_STATUS;
            qf.piece  = 3'(k);
            qf.data   = row.typed ? row.data_bytes[k] : timecode_data_byte(row.count, 3'(k));
            qf.last   = (3'(k) == PIECE_HR_RATE);
            pending_quarter_frames.push_back(qf);
         end
      end
   endtask

   // lower start for a while; the request fields wander so stale data is never trusted
   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         start           <= 1'b0;
         req_frame_count <= $urandom;
         req_is_playing  <= 1'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   // mostly back to back or short, now and then long enough to let the emitter run dry
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 9);
      return $urandom_range(12, 40);
   endfunction

   // random beat: full-range words, realistic positions, hour-wrap edges, negatives, first-minute positions
   function automatic stim_row_type random_row();
      stim_row_type row;
      int           kind;
      row      = '0;
      kind     = $urandom_range(99);
      if (kind < 35)
         row.count = $urandom;
      else if (kind < 75)
         row.count = $urandom_range(0, 3 * 3348000);
      else if (kind < 85)
         // right around a multiple of 31 hours, where the hour count wraps
         row.count = $urandom_range(0, 641) * 3348000 + $urandom_range(0, 2) - 1;
      else if (kind < 92)
         row.count = -$urandom_range(1, 1000);
      else
         row.count = $urandom_range(0, 29) + FPS * $urandom_range(0, 59);
      row.playing = ($urandom_range(99) < 75);
      return row;
   endfunction

   // sender holds off until every owed quarter frame has shown up or DRAIN_LIMIT runs out
   task automatic wait_drained();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (pending_quarter_frames.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_quarter_frames.size() != 0) begin
         report_mismatch("beats never delivered", pending_quarter_frames.size(), 0);
         pending_quarter_frames.delete();
      end
   endtask

   // output side: every strobed beat is checked against the oldest owed one
   always @(posedge clock) begin
      qf_beat_type want;
      if (!reset && rsp_strobe) begin
         if (pending_quarter_frames.size() == 0) begin
            report_mismatch("beat with nothing pending, data byte",
                            32'(rsp_data_byte), 0);
         end else begin
            want = pending_quarter_frames.pop_front();
            beats_checked++;
            if (rsp_status_byte !== want.status)
               report_mismatch("status byte", 32'(rsp_status_byte), 32'(want.status));
            if (rsp_data_byte !== want.data)
               report_mismatch("data byte", 32'(rsp_data_byte), 32'(want.data));
            if (rsp_piece_index !== want.piece)
               report_mismatch("piece index", 32'(rsp_piece_index), 32'(want.piece));
            if (rsp_last_piece !== want.last)
               report_mismatch("last piece", 32'(rsp_last_piece), 32'(want.last));
         end
      end
   end

   initial begin
      // directed table: clamping, extremes, nibble carries, hour bit 4, hour wrap, idle beats
      directed_rows = '{
         '{32'd0,          1'b1, 1'b1, ORIGIN_BYTES},   // origin
         '{32'hFFFF_FFFF,  1'b1, 1'b1, ORIGIN_BYTES},   // minus one, clamped
         '{32'h8000_0000,  1'b1, 1'b1, ORIGIN_BYTES},   // most negative, clamped
         '{32'hFFFF_FC18,  1'b1, 1'b1, ORIGIN_BYTES},   // minus a thousand
         '{32'd1728000,    1'b1, 1'b1, HOUR16_BYTES},   // hour sixteen sets hour bit 4
         '{32'd3348000,    1'b1, 1'b1, ORIGIN_BYTES},   // 31 hours wrap to zero
         '{32'h7FFF_FFFF,  1'b1, 1'b0, '0},             // largest position
         '{32'd3347999,    1'b1, 1'b0, '0},             // last frame before the wrap
         '{32'd1,          1'b1, 1'b0, '0},
         '{32'd15,         1'b1, 1'b0, '0},
         '{32'd16,         1'b1, 1'b0, '0},             // frames high nibble set
         '{32'd29,         1'b1, 1'b0, '0},
         '{32'd30,         1'b1, 1'b0, '0},             // first second
         '{32'd1799,       1'b1, 1'b0, '0},
         '{32'd1800,       1'b1, 1'b0, '0},             // first minute
         '{32'd107999,     1'b1, 1'b0, '0},
         '{32'd108000,     1'b1, 1'b0, '0},             // first hour
         '{32'h5555_5555,  1'b1, 1'b0, '0},
         '{32'h2AAA_AAAA,  1'b1, 1'b0, '0},
         '{32'h7FFF_FFFF,  1'b0, 1'b0, '0},             // not playing: nothing out
         '{32'h8000_0000,  1'b0, 1'b0, '0},
         '{32'd12345,      1'b0, 1'b0, '0}
      };

      // synchronous reset, once
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_beat(directed_rows[i]);
         idle_gap(pick_gap());
      end
      wait_drained();

      // random part, with bursts of back-to-back beats and a mid-run drain
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         send_beat(random_row());
         if (i == RANDOM_BEATS / 2)
            wait_drained();
         else if ((i / 16) % 4 == 1)
            idle_gap(0);
         else
            idle_gap(pick_gap());
      end

      wait_drained();
      // let any stray strobes surface after the last owed beat
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d input beats (%0d playing), %0d quarter-frame beats checked",
               beats_in, playing_in, beats_checked);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("mtc_quarter_frame_generator test passed");
      end else begin
         $display("mtc_quarter_frame_generator test failed");
      end
      $finish;
   end

endmodule
